@@ rtl/core/matmul_reuse_greedy_scheduler_top_assert.svh @@
// ----------------------------------------------------------------------------
// matmul reuse scheduler assertion macros
// concurrent check helpers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef MATMUL_REUSE_GREEDY_SCHEDULER_TOP_ASSERT_SVH
`define MATMUL_REUSE_GREEDY_SCHEDULER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MRGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MRGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MRGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MRGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/core/mrgs_pkg.sv @@
// ----------------------------------------------------------------------------
// mrgs_pkg
// shared constants, controller states and command word of the reuse scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package mrgs_pkg;

  localparam int unsigned MAX_OPS_DEF  = 16;
  localparam int unsigned TAG_BITS_DEF = 16;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned SCORE_W      = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LSCAN,
    ST_LDRAIN,
    ST_SINIT,
    ST_SLOAD0,
    ST_SSCAN,
    ST_SDRAIN,
    ST_STEP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic lcmp;
    logic scmp;
    logic best_clr;
    logic init0;
    logic prev_ld0;
    logic step;
    logic fin;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/mrgs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrgs_ctrl
// sequencer for loading, dependency scan, slot selection and emission
// ----------------------------------------------------------------------------
`default_nettype none

module mrgs_ctrl #(
  parameter int unsigned MAX_OPS = mrgs_pkg::MAX_OPS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          last_in_i,
  output logic                               busy_o,
  output mrgs_pkg::cmd_t                     cmd_o,
  output logic [$clog2(MAX_OPS)-1:0]         wr_addr_o,
  output logic [$clog2(MAX_OPS)-1:0]         rd_addr_o
);

  localparam int unsigned IDX_W = $clog2(MAX_OPS);
  localparam int unsigned CNT_W = $clog2(MAX_OPS + 1);

  mrgs_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic              close_q, close_d;
  logic              close_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrgs_pkg::ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      slot_q  <= '0;
      close_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      slot_q  <= slot_d;
      close_q <= close_d;
    end
  end

  assign close_now = last_in_i || (cnt_q == CNT_W'(MAX_OPS - 1));
  assign wr_addr_o = cnt_q[IDX_W-1:0];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    slot_d    = slot_q;
    close_d   = close_q;
    cmd_o     = '0;
    rd_addr_o = k_q;
    busy_o    = 1'b1;
    case (state_q)
      mrgs_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = cnt_q + CNT_W'(1);
          close_d    = close_now;
          k_d        = '0;
          if (cnt_q != '0) begin
            state_d = mrgs_pkg::ST_LSCAN;
          end else if (close_now) begin
            state_d = mrgs_pkg::ST_SINIT;
          end
        end
      end
      mrgs_pkg::ST_LSCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.lcmp  = 1'b1;
        k_d         = k_q + IDX_W'(1);
        if (CNT_W'(k_q) == cnt_q - CNT_W'(2)) begin
          state_d = mrgs_pkg::ST_LDRAIN;
        end
      end
      mrgs_pkg::ST_LDRAIN: begin
        state_d = close_q ? mrgs_pkg::ST_SINIT : mrgs_pkg::ST_IDLE;
      end
      mrgs_pkg::ST_SINIT: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.init0 = 1'b1;
        rd_addr_o   = '0;
        slot_d      = IDX_W'(1);
        state_d     = mrgs_pkg::ST_SLOAD0;
      end
      mrgs_pkg::ST_SLOAD0: begin
        cmd_o.prev_ld0 = 1'b1;
        k_d            = '0;
        state_d        = (cnt_q == CNT_W'(1)) ? mrgs_pkg::ST_FIN : mrgs_pkg::ST_SSCAN;
      end
      mrgs_pkg::ST_SSCAN: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.scmp     = 1'b1;
        cmd_o.best_clr = (k_q == '0);
        k_d            = k_q + IDX_W'(1);
        if (CNT_W'(k_q) == cnt_q - CNT_W'(1)) begin
          k_d     = '0;
          state_d = mrgs_pkg::ST_SDRAIN;
        end
      end
      mrgs_pkg::ST_SDRAIN: begin
        state_d = mrgs_pkg::ST_STEP;
      end
      mrgs_pkg::ST_STEP: begin
        cmd_o.step = 1'b1;
        slot_d     = slot_q + IDX_W'(1);
        if (CNT_W'(slot_q) == cnt_q - CNT_W'(1)) begin
          state_d = mrgs_pkg::ST_FIN;
        end else begin
          state_d = mrgs_pkg::ST_SSCAN;
        end
      end
      mrgs_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
        cnt_d     = '0;
        state_d   = mrgs_pkg::ST_IDLE;
      end
      default: begin
        state_d = mrgs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/mrgs_dpath.sv @@
// ----------------------------------------------------------------------------
// mrgs_dpath
// op store, dependency matrix, candidate scoring and result word registers
// ----------------------------------------------------------------------------
`default_nettype none

module mrgs_dpath #(
  parameter int unsigned MAX_OPS  = mrgs_pkg::MAX_OPS_DEF,
  parameter int unsigned TAG_BITS = mrgs_pkg::TAG_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mrgs_pkg::cmd_t                cmd_i,
  input  wire logic [$clog2(MAX_OPS)-1:0]    wr_addr_i,
  input  wire logic [$clog2(MAX_OPS)-1:0]    rd_addr_i,
  input  wire logic [TAG_BITS-1:0]           a_tag_i,
  input  wire logic [TAG_BITS-1:0]           b_tag_i,
  input  wire logic [TAG_BITS-1:0]           c_tag_i,
  input  wire logic [TAG_BITS-1:0]           result_tag_i,
  input  wire logic                          supports_reuse_i,
  output logic                               out_valid_o,
  output logic [mrgs_pkg::POS_W-1:0]         op_position_o,
  output logic                               reuse_a_o,
  output logic                               reuse_b_o,
  output logic                               last_out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_OPS);
  localparam int unsigned ENT_W = 4 * TAG_BITS + 1;
  localparam int unsigned SW    = mrgs_pkg::SCORE_W;

  // op store: {reuse, result, c, b, a}
  logic [ENT_W-1:0]    mem_q [MAX_OPS];
  logic [ENT_W-1:0]    rdata_q;
  logic [TAG_BITS-1:0] ent_a, ent_b, ent_c, ent_r;
  logic                ent_cap;

  logic [MAX_OPS-1:0]  dep_q [MAX_OPS];
  logic [MAX_OPS-1:0]  pend_q;
  logic [MAX_OPS-1:0]  rdy_vec;

  logic [IDX_W-1:0]    cidx_q, nidx_q;
  logic                lcmp_vld_q, scmp_vld_q;
  logic [TAG_BITS-1:0] new_a_q, new_b_q, new_c_q, new_r_q;

  logic [TAG_BITS-1:0] prev_a_q, prev_b_q, prev_r_q;
  logic                prev_cap_q;
  logic [IDX_W-1:0]    prev_pos_q;

  logic                best_vld_q;
  logic [SW-1:0]       best_score_q;
  logic [TAG_BITS-1:0] best_a_q, best_b_q, best_r_q;
  logic                best_cap_q;
  logic [IDX_W-1:0]    best_pos_q;

  logic                fb_vld_q;
  logic [TAG_BITS-1:0] fb_a_q, fb_b_q, fb_r_q;
  logic                fb_cap_q;
  logic [IDX_W-1:0]    fb_pos_q;

  logic [TAG_BITS-1:0] sel_a, sel_b, sel_r;
  logic                sel_cap;
  logic [IDX_W-1:0]    sel_pos;

  logic                hit_fwd, hit_bwd;
  logic                same_a, same_b, same_c;
  logic [SW-1:0]       score;
  logic                elig, take_best;

  logic                out_vld_q;
  logic [mrgs_pkg::POS_W-1:0] out_pos_q;
  logic                out_ra_q, out_rb_q, out_last_q;

  assign ent_a   = rdata_q[TAG_BITS-1:0];
  assign ent_b   = rdata_q[2*TAG_BITS-1:TAG_BITS];
  assign ent_c   = rdata_q[3*TAG_BITS-1:2*TAG_BITS];
  assign ent_r   = rdata_q[4*TAG_BITS-1:3*TAG_BITS];
  assign ent_cap = rdata_q[ENT_W-1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_q[wr_addr_i] <= {supports_reuse_i, result_tag_i, c_tag_i, b_tag_i, a_tag_i};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // dependency hits between the op being loaded and a stored op
  assign hit_fwd = (ent_r == new_a_q) || (ent_r == new_b_q) || (ent_r == new_c_q);
  assign hit_bwd = (new_r_q == ent_a) || (new_r_q == ent_b) || (new_r_q == ent_c);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dep_q[wr_addr_i] <= '0;
      nidx_q           <= wr_addr_i;
      new_a_q          <= a_tag_i;
      new_b_q          <= b_tag_i;
      new_c_q          <= c_tag_i;
      new_r_q          <= result_tag_i;
    end
    if (lcmp_vld_q) begin
      dep_q[nidx_q][cidx_q] <= hit_fwd;
      dep_q[cidx_q][nidx_q] <= hit_bwd;
    end
    if (cmd_i.rd_en) begin
      cidx_q <= rd_addr_i;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_OPS; j++) begin
      rdy_vec[j] = ~|(dep_q[j] & pend_q);
    end
  end

  // candidate scoring against the previous op
  assign same_a    = (ent_a == prev_a_q);
  assign same_b    = (ent_b == prev_b_q);
  assign same_c    = (ent_c == prev_r_q);
  assign score     = {same_a & same_b, same_a ^ same_b, same_c};
  assign elig      = scmp_vld_q && pend_q[cidx_q];
  assign take_best = elig && rdy_vec[cidx_q] && (!best_vld_q || (score > best_score_q));

  always_comb begin
    if (best_vld_q) begin
      sel_a   = best_a_q;
      sel_b   = best_b_q;
      sel_r   = best_r_q;
      sel_cap = best_cap_q;
      sel_pos = best_pos_q;
    end else begin
      sel_a   = fb_a_q;
      sel_b   = fb_b_q;
      sel_r   = fb_r_q;
      sel_cap = fb_cap_q;
      sel_pos = fb_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcmp_vld_q <= 1'b0;
      scmp_vld_q <= 1'b0;
      pend_q     <= '0;
      best_vld_q <= 1'b0;
      fb_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      lcmp_vld_q <= cmd_i.rd_en && cmd_i.lcmp;
      scmp_vld_q <= cmd_i.rd_en && cmd_i.scmp;
      out_vld_q  <= cmd_i.step || cmd_i.fin;
      if (cmd_i.load) begin
        pend_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.init0) begin
        pend_q[0] <= 1'b0;
      end
      if (cmd_i.step) begin
        pend_q[sel_pos] <= 1'b0;
      end
      if (cmd_i.best_clr) begin
        best_vld_q <= 1'b0;
        fb_vld_q   <= 1'b0;
      end else begin
        if (take_best) begin
          best_vld_q <= 1'b1;
        end
        if (elig) begin
          fb_vld_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_score_q <= score;
      best_a_q     <= ent_a;
      best_b_q     <= ent_b;
      best_r_q     <= ent_r;
      best_cap_q   <= ent_cap;
      best_pos_q   <= cidx_q;
    end
    if (elig && !fb_vld_q) begin
      fb_a_q   <= ent_a;
      fb_b_q   <= ent_b;
      fb_r_q   <= ent_r;
      fb_cap_q <= ent_cap;
      fb_pos_q <= cidx_q;
    end
    if (cmd_i.prev_ld0) begin
      prev_a_q   <= ent_a;
      prev_b_q   <= ent_b;
      prev_r_q   <= ent_r;
      prev_cap_q <= ent_cap;
      prev_pos_q <= '0;
    end else if (cmd_i.step) begin
      prev_a_q   <= sel_a;
      prev_b_q   <= sel_b;
      prev_r_q   <= sel_r;
      prev_cap_q <= sel_cap;
      prev_pos_q <= sel_pos;
    end
    if (cmd_i.step) begin
      out_pos_q  <= mrgs_pkg::POS_W'(prev_pos_q);
      out_ra_q   <= prev_cap_q && (sel_a == prev_a_q);
      out_rb_q   <= prev_cap_q && (sel_b == prev_b_q);
      out_last_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_pos_q  <= mrgs_pkg::POS_W'(prev_pos_q);
      out_ra_q   <= 1'b0;
      out_rb_q   <= 1'b0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign op_position_o = out_pos_q;
  assign reuse_a_o     = out_ra_q;
  assign reuse_b_o     = out_rb_q;
  assign last_out_o    = out_last_q;

endmodule

`default_nettype wire

@@ rtl/core/matmul_reuse_greedy_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// matmul_reuse_greedy_scheduler_top
// loads a run of matrix-multiply ops and re-emits them in a reuse-friendly order
// ----------------------------------------------------------------------------
// An op is taken when start is high and busy is low. Loading op n (counted from
// zero) keeps busy high after the accepting edge while the n stored ops before
// it are read back one per cycle through the single read port of the op store
// to build the dependency matrix; op 0 of a run needs no scan and leaves busy
// low unless it closes the run. The op that closes the run (last_in set, or the
// store full) then starts the ordering: SINIT and SLOAD0 fetch the first op,
// then for each of the remaining N-1 slots SSCAN reads all N stored ops, one
// per cycle, and SDRAIN and STEP settle and commit the choice; FIN ends the run.
// One result word is shown for one cycle with out_valid_o as each slot is
// committed and the last one after FIN; the receiver cannot stall and must
// take every word as it appears.
`default_nettype none

`include "matmul_reuse_greedy_scheduler_top_assert.svh"

module matmul_reuse_greedy_scheduler_top #(
  parameter int unsigned MAX_OPS  = mrgs_pkg::MAX_OPS_DEF,
  parameter int unsigned TAG_BITS = mrgs_pkg::TAG_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [TAG_BITS-1:0]           a_tag_i,
  input  wire logic [TAG_BITS-1:0]           b_tag_i,
  input  wire logic [TAG_BITS-1:0]           c_tag_i,
  input  wire logic [TAG_BITS-1:0]           result_tag_i,
  input  wire logic                          supports_reuse_i,
  input  wire logic                          last_in_i,
  output logic                               out_valid_o,
  output logic [mrgs_pkg::POS_W-1:0]         op_position_o,
  output logic                               reuse_a_o,
  output logic                               reuse_b_o,
  output logic                               last_out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_OPS);

  mrgs_pkg::cmd_t   cmd;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  mrgs_ctrl #(
    .MAX_OPS (MAX_OPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .last_in_i (last_in_i),
    .busy_o    (busy),
    .cmd_o     (cmd),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr)
  );

  mrgs_dpath #(
    .MAX_OPS  (MAX_OPS),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .wr_addr_i        (wr_addr),
    .rd_addr_i        (rd_addr),
    .a_tag_i          (a_tag_i),
    .b_tag_i          (b_tag_i),
    .c_tag_i          (c_tag_i),
    .result_tag_i     (result_tag_i),
    .supports_reuse_i (supports_reuse_i),
    .out_valid_o      (out_valid_o),
    .op_position_o    (op_position_o),
    .reuse_a_o        (reuse_a_o),
    .reuse_b_o        (reuse_b_o),
    .last_out_o       (last_out_o)
  );

  // closing word of a run is alone and carries no reuse; a closing load raises busy, and words come only after busy
  `MRGS_ASSERT_NXT(a_last_gap, clk_i, rst_ni, out_valid_o && last_out_o, !out_valid_o, "word after last")
  `MRGS_ASSERT_IMP(a_last_flags, clk_i, rst_ni, out_valid_o && last_out_o, !reuse_a_o && !reuse_b_o, "reuse on last")
  `MRGS_ASSERT_NXT(a_close_busy, clk_i, rst_ni, start && !busy && last_in_i, busy, "no busy on close")
  `MRGS_ASSERT_IMP(a_word_src, clk_i, rst_ni, out_valid_o, $past(busy), "word while idle")

endmodule

`default_nettype wire
